FILE: rtl/svcp_pkg.sv
// Shared types, command codes and the width scaling function for the servo positioner.
`default_nettype none

package svcp_pkg;

   localparam int SERVO_COUNT = 3;

   // Serial command characters
   localparam logic [7:0] CHAR_SEL1 = 8'h31;  // '1'
   localparam logic [7:0] CHAR_SEL3 = 8'h33;  // '3'
   localparam logic [7:0] CHAR_ADC  = 8'h34;  // '4'
   localparam logic [7:0] CHAR_SER  = 8'h35;  // '5'
   localparam logic [7:0] CHAR_UP   = 8'h77;  // 'w'
   localparam logic [7:0] CHAR_DOWN = 8'h71;  // 'q'

   // Configuration register indexes
   localparam logic [1:0] REG_MIN_WIDTH = 2'd0;
   localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
   localparam logic [1:0] REG_STEP_SIZE = 2'd2;

   // Reset values
   localparam logic [7:0] MIN_WIDTH_RESET = 8'd42;
   localparam logic [7:0] MAX_WIDTH_RESET = 8'd217;
   localparam logic [6:0] STEP_SIZE_RESET = 7'd5;
   localparam logic [7:0] POS_RESET       = 8'd127;

   localparam logic [1:0] CHAN_FIRST = 2'd0;
   localparam logic [1:0] CHAN_LAST  = 2'd2;
   localparam logic [1:0] SERVO_NONE = 2'd0;

   typedef logic [7:0] byte_type;

   // Values handed from the command stage to the output stage
   typedef struct packed {
      byte_type [SERVO_COUNT-1:0] src;
      logic                       serial;
      logic [1:0]                 selected;
      logic [1:0]                 channel;
   } stage_type;

   // src * span / 255 + min, span clamped at zero; exact divide by 255 for
   // products of two bytes: (x + 1 + (x >> 8)) >> 8
   function automatic byte_type scale_width(input byte_type src, input byte_type min_w,
                                            input byte_type max_w);
      byte_type    span;
      logic [15:0] prod;
      logic [15:0] adj;
      byte_type    quot;
      span = (max_w >= min_w) ? byte_type'(max_w - min_w) : 8'd0;
      prod = 16'(src) * 16'(span);
      adj  = prod + 16'd1 + {8'd0, prod[15:8]};
      quot = adj[15:8];
      return byte_type'(quot + min_w);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/svcp_chan_if.sv
// Valid/ready channel interfaces for command input and width results.
`default_nettype none

interface svcp_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;

   modport source (output valid, output mode, output data_byte, input ready);
   modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface svcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] width_one;
   logic [7:0] width_two;
   logic [7:0] width_three;
   logic       serial_in_control;
   logic [1:0] selected_servo;
   logic [1:0] next_channel;

   modport source (output valid, output width_one, output width_two, output width_three,
                   output serial_in_control, output selected_servo, output next_channel,
                   input ready);
   modport sink   (input valid, input width_one, input width_two, input width_three,
                   input serial_in_control, input selected_servo, input next_channel,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/three_servo_command_positioner.sv
// Top level of the three-servo command positioner.
`default_nettype none

// Takes one item per cycle (serial command byte or ADC sample) and returns one
// result per item: three scaled pulse widths plus control status. Each item
// passes the command stage, which updates positions, samples and flags into
// the stage register, and then the output stage, where three 8x8 multipliers
// and an exact divide by 255 form each width. Sustained rate is one item per
// clock; rsp_chan.ready stalls both stages. The user writes configuration
// registers (min_width, max_width, step_size) only while no item is in flight,
// through csr_we/csr_index/csr_wdata; the block itself does not enforce this.
module three_servo_command_positioner (
   input  wire logic       clock,
   input  wire logic       reset,
   svcp_req_if.sink        req_chan,
   svcp_rsp_if.source      rsp_chan,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import svcp_pkg::*;

   byte_type   min_width_ff;
   byte_type   max_width_ff;
   logic [6:0] step_size_ff;
   logic       stage_valid;
   stage_type  stage_data;
   logic       out_take;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_WIDTH_RESET;
         max_width_ff <= MAX_WIDTH_RESET;
         step_size_ff <= STEP_SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MIN_WIDTH: min_width_ff <= csr_wdata;
            REG_MAX_WIDTH: max_width_ff <= csr_wdata;
            REG_STEP_SIZE: step_size_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   svcp_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_mode     (req_chan.mode),
      .in_data     (req_chan.data_byte),
      .step_size   (step_size_ff),
      .out_take    (out_take),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   svcp_out u_out (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .min_width   (min_width_ff),
      .max_width   (max_width_ff),
      .out_take    (out_take),
      .rsp         (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: rtl/svcp_ctl.sv
// Command stage: servo positions, ADC samples, control flags and the stage register.
`default_nettype none

module svcp_ctl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic                in_mode,
   input  wire logic [7:0]          in_data,
   input  wire logic [6:0]          step_size,
   input  wire logic                out_take,
   output logic                     stage_valid,
   output svcp_pkg::stage_type      stage_data
);
   import svcp_pkg::*;

   byte_type [SERVO_COUNT-1:0] pos_ff, pos_in;
   byte_type [SERVO_COUNT-1:0] smp_ff, smp_in;
   logic                       serial_ff, serial_in;
   logic [1:0]                 chosen_ff, chosen_in;
   logic [1:0]                 chan_ff, chan_in;
   logic                       stage_valid_ff;
   stage_type                  stage_ff, stage_in;

   logic       accept;
   logic       advance;
   logic [1:0] sel_idx;
   byte_type   cur_pos;
   logic [8:0] up_sum;
   byte_type   new_pos;

   assign advance  = stage_valid_ff && out_take;
   assign in_ready = !stage_valid_ff || advance;
   assign accept   = in_valid && in_ready;

   // Step the selected position within 0..255
   assign sel_idx = chosen_ff - 2'd1;
   assign cur_pos = pos_ff[sel_idx];
   assign up_sum  = {1'b0, cur_pos} + {2'b00, step_size};

   always_comb begin
      new_pos = cur_pos;
      if (in_data == CHAR_UP) begin
         if (!up_sum[8]) new_pos = up_sum[7:0];
      end else if (cur_pos >= {1'b0, step_size}) begin
         new_pos = cur_pos - {1'b0, step_size};
      end
   end

   // Next state for one accepted item
   always_comb begin
      pos_in    = pos_ff;
      smp_in    = smp_ff;
      serial_in = serial_ff;
      chosen_in = chosen_ff;
      chan_in   = chan_ff;
      if (in_mode) begin
         if (chan_ff == CHAN_LAST) begin
            smp_in[chan_ff] = in_data;
            chan_in         = CHAN_FIRST;
         end else if (chan_ff < CHAN_LAST) begin
            smp_in[chan_ff] = in_data;
            chan_in         = chan_ff + 2'd1;
         end else begin
            chan_in = CHAN_FIRST;
         end
      end else begin
         priority if (in_data >= CHAR_SEL1 && in_data <= CHAR_SEL3) begin
            chosen_in = in_data[1:0];
         end else if (in_data == CHAR_ADC) begin
            serial_in = 1'b0;
         end else if (in_data == CHAR_SER) begin
            serial_in = 1'b1;
            pos_in    = smp_ff;
         end else if ((in_data == CHAR_UP || in_data == CHAR_DOWN) && chosen_ff != SERVO_NONE) begin
            pos_in[sel_idx] = new_pos;
         end else begin
            pos_in = pos_ff;
         end
      end
   end

   // Stage payload reflects the state after this item
   always_comb begin
      stage_in.src      = serial_in ? pos_in : smp_in;
      stage_in.serial   = serial_in;
      stage_in.selected = chosen_in;
      stage_in.channel  = chan_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= {SERVO_COUNT{POS_RESET}};
         smp_ff         <= '0;
         serial_ff      <= 1'b1;
         chosen_ff      <= SERVO_NONE;
         chan_ff        <= CHAN_FIRST;
         stage_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff    <= pos_in;
            smp_ff    <= smp_in;
            serial_ff <= serial_in;
            chosen_ff <= chosen_in;
            chan_ff   <= chan_in;
         end
         if (accept) stage_valid_ff <= 1'b1;
         else if (advance) stage_valid_ff <= 1'b0;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (accept) stage_ff <= stage_in;
   end

   assign stage_valid = stage_valid_ff;
   assign stage_data  = stage_ff;

   // Checks
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff != 2'd3) else $error("channel pointer out of range");

   a_chan_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && in_mode && chan_ff == CHAN_LAST |=> chan_ff == CHAN_FIRST)
      else $error("channel pointer did not wrap");

   a_adc_cmd: assert property (@(posedge clock) disable iff (reset)
      accept && !in_mode && in_data == CHAR_ADC |=> !serial_ff && !stage_ff.serial)
      else $error("ADC control command not applied");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_take |=> stage_valid_ff && $stable(stage_ff))
      else $error("stage lost while output stalled");

endmodule

`default_nettype wire

FILE: rtl/svcp_out.sv
// Output stage: scales the three source values to pulse widths and holds the result.
`default_nettype none

module svcp_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                stage_valid,
   input  wire svcp_pkg::stage_type stage_data,
   input  wire logic [7:0]          min_width,
   input  wire logic [7:0]          max_width,
   output logic                     out_take,
   svcp_rsp_if.source               rsp
);
   import svcp_pkg::*;

   logic                       valid_ff;
   byte_type [SERVO_COUNT-1:0] width_ff, width_in;
   logic                       serial_ff;
   logic [1:0]                 selected_ff;
   logic [1:0]                 channel_ff;
   logic                       load;

   assign out_take = !valid_ff || rsp.ready;
   assign load     = stage_valid && out_take;

   // One scaler per servo
   always_comb begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
         width_in[i] = scale_width(stage_data.src[i], min_width, max_width);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (out_take) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         width_ff    <= width_in;
         serial_ff   <= stage_data.serial;
         selected_ff <= stage_data.selected;
         channel_ff  <= stage_data.channel;
      end
   end

   assign rsp.valid             = valid_ff;
   assign rsp.width_one         = width_ff[0];
   assign rsp.width_two         = width_ff[1];
   assign rsp.width_three       = width_ff[2];
   assign rsp.serial_in_control = serial_ff;
   assign rsp.selected_servo    = selected_ff;
   assign rsp.next_channel      = channel_ff;

endmodule

`default_nettype wire

FILE: tb/svcp_width_checker.sv
`timescale 1ns / 1ps
// Channel monitor that predicts each width report of the servo positioner and compares it.
module svcp_width_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic       req_mode,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [7:0] rsp_width_one,
   input  wire logic [7:0] rsp_width_two,
   input  wire logic [7:0] rsp_width_three,
   input  wire logic       rsp_serial_in_control,
   input  wire logic [1:0] rsp_selected_servo,
   input  wire logic [1:0] rsp_next_channel,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   output int              mismatch_count,
   output int              pending_results
);
   import svcp_pkg::*;

   localparam int FULL_SCALE = 255;

   typedef struct packed {
      byte_type [SERVO_COUNT-1:0] width;
      logic                       serial;
      logic [1:0]                 selected;
      logic [1:0]                 channel;
   } servo_report_type;

   // Shadow copy of the block state and settings
   byte_type   positions [SERVO_COUNT];
   byte_type   samples [SERVO_COUNT];
   logic       serial_ctrl;
   logic [1:0] chosen;
   logic [1:0] chan_ptr;
   byte_type   min_w;
   byte_type   max_w;
   logic [6:0] step;

   servo_report_type expected_reports [$];
   servo_report_type oldest_report;

   // value * span / 255 + min, span clamped at zero for max below min
   function automatic byte_type scaled_width(input byte_type value);
      int span;
      int full;
      span = (max_w >= min_w) ? int'(max_w) - int'(min_w) : 0;
      full = int'(value) * span / FULL_SCALE + int'(min_w);
      return byte_type'(full);
   endfunction

   // Serial byte: select, switch control source, or step the selected position
   task automatic take_command(input byte_type code);
      int pos;
      if (code >= CHAR_SEL1 && code <= CHAR_SEL3) begin
         chosen = 2'(code - CHAR_SEL1 + 8'd1);
      end else if (code == CHAR_ADC) begin
         serial_ctrl = 1'b0;
      end else if (code == CHAR_SER) begin
         serial_ctrl = 1'b1;
         for (int k = 0; k < SERVO_COUNT; k++) positions[k] = samples[k];
      end else if ((code == CHAR_UP || code == CHAR_DOWN) && chosen != SERVO_NONE) begin
         pos = positions[chosen-1];
         if (code == CHAR_UP) begin
            if (pos <= FULL_SCALE - int'(step)) pos += step;
         end else begin
            if (pos >= int'(step)) pos -= step;
         end
         positions[chosen-1] = byte_type'(pos);
      end
   endtask

   // ADC sample fills the current channel, pointer rotates
   task automatic take_sample(input byte_type value);
      samples[chan_ptr] = value;
      chan_ptr = (chan_ptr == CHAN_LAST) ? CHAN_FIRST : chan_ptr + 2'd1;
   endtask

   function automatic servo_report_type current_report();
      servo_report_type r;
      for (int k = 0; k < SERVO_COUNT; k++)
         r.width[k] = scaled_width(serial_ctrl ? positions[k] : samples[k]);
      r.serial   = serial_ctrl;
      r.selected = chosen;
      r.channel  = chan_ptr;
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SERVO_COUNT; k++) begin
            positions[k] = POS_RESET;
            samples[k]   = 8'd0;
         end
         serial_ctrl    = 1'b1;
         chosen         = SERVO_NONE;
         chan_ptr       = CHAN_FIRST;
         min_w          = MIN_WIDTH_RESET;
         max_w          = MAX_WIDTH_RESET;
         step           = STEP_SIZE_RESET;
         mismatch_count = 0;
         expected_reports.delete();
      end else begin
         // register writes only happen while idle
         if (csr_we) begin
            case (csr_index)
               REG_MIN_WIDTH: min_w = csr_wdata;
               REG_MAX_WIDTH: max_w = csr_wdata;
               REG_STEP_SIZE: step = csr_wdata[6:0];
               default: ;
            endcase
         end

         // result transfer against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with nothing expected, expected none, got %0d %0d %0d",
                        $time, rsp_width_one, rsp_width_two, rsp_width_three);
            end else begin
               oldest_report = expected_reports.pop_front();
               compare_field("width_one", oldest_report.width[0], rsp_width_one);
               compare_field("width_two", oldest_report.width[1], rsp_width_two);
               compare_field("width_three", oldest_report.width[2], rsp_width_three);
               compare_field("serial_in_control", oldest_report.serial,
                             rsp_serial_in_control);
               compare_field("selected_servo", oldest_report.selected, rsp_selected_servo);
               compare_field("next_channel", oldest_report.channel, rsp_next_channel);
            end
         end

         // input transfer: update shadow state, queue the report it causes
         if (req_valid && req_ready) begin
            if (req_mode) take_sample(req_data_byte);
            else take_command(req_data_byte);
            expected_reports.push_back(current_report());
         end
      end
      pending_results = expected_reports.size();
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, command and sample stimulus, result back-pressure and verdict.
module tb;
   import svcp_pkg::*;

   localparam logic MODE_SERIAL     = 1'b0;
   localparam logic MODE_ADC        = 1'b1;
   localparam int   GAP_MAX         = 12;
   localparam int   ITEMS_PER_PHASE = 100;
   localparam int   LONG_HOLD       = 120;
   localparam int   STALL_LIMIT     = 2000;
   localparam int   SETTLE_CYCLES   = 10;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we;
   logic [1:0] csr_index;
   logic [7:0] csr_wdata;
   int         mismatch_count;
   int         pending_results;
   int         quiet_cycles = 0;

   svcp_req_if req_chan ();
   svcp_rsp_if rsp_chan ();

   three_servo_command_positioner u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   svcp_width_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_chan.valid),
      .req_ready            (req_chan.ready),
      .req_mode             (req_chan.mode),
      .req_data_byte        (req_chan.data_byte),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_width_one        (rsp_chan.width_one),
      .rsp_width_two        (rsp_chan.width_two),
      .rsp_width_three      (rsp_chan.width_three),
      .rsp_serial_in_control(rsp_chan.serial_in_control),
      .rsp_selected_servo   (rsp_chan.selected_servo),
      .rsp_next_channel     (rsp_chan.next_channel),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .pending_results      (pending_results)
   );

   always #5 clock = ~clock;

   // gap before an item; calm stretches run back to back
   function automatic int draw_gap(input bit calm);
      if (calm || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, GAP_MAX);
   endfunction

   // Called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input logic cmd_mode, input byte_type cmd_byte, input bit calm);
      int gap;
      gap = draw_gap(calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.mode      <= cmd_mode;
      req_chan.data_byte <= cmd_byte;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   // Stop offering and wait until every predicted report has come back
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic set_widths(input byte_type min_value, input byte_type max_value,
                             input logic [6:0] step_value);
      write_reg(REG_MIN_WIDTH, min_value);
      write_reg(REG_MAX_WIDTH, max_value);
      write_reg(REG_STEP_SIZE, {1'b0, step_value});
      csr_we <= 1'b0;
   endtask

   // Mostly select/step sequences with mode switches, samples and stray bytes mixed in
   task automatic send_random(input int count);
      int       pick;
      bit       calm;
      logic     cmd_mode;
      byte_type cmd_byte;
      calm = 1'b0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 29) == 0) calm = !calm;
         pick     = $urandom_range(0, 99);
         cmd_mode = MODE_SERIAL;
         if (pick < 25) begin
            cmd_mode = MODE_ADC;
            cmd_byte = byte_type'($urandom_range(0, 255));
         end else if (pick < 40) begin
            cmd_byte = CHAR_SEL1 + byte_type'($urandom_range(0, 2));
         end else if (pick < 60) begin
            cmd_byte = CHAR_UP;
         end else if (pick < 80) begin
            cmd_byte = CHAR_DOWN;
         end else if (pick < 85) begin
            cmd_byte = CHAR_ADC;
         end else if (pick < 90) begin
            cmd_byte = CHAR_SER;
         end else begin
            cmd_byte = byte_type'($urandom_range(0, 255));
         end
         send_item(cmd_mode, cmd_byte, calm);
         if ($urandom_range(0, 79) == 0) wait_for_results();
      end
   endtask

   // Result side: random stalls, calm stretches, two long hold-offs to back up the block
   initial begin
      int gap;
      bit calm;
      int tally;
      rsp_chan.ready = 1'b0;
      calm  = 1'b0;
      tally = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0) calm = !calm;
         gap = (tally == 150 || tally == 450) ? LONG_HOLD : draw_gap(calm);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         tally++;
         @(negedge clock);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.mode      = MODE_SERIAL;
      req_chan.data_byte = 8'd0;
      csr_we             = 1'b0;
      csr_index          = REG_MIN_WIDTH;
      csr_wdata          = 8'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // steps with no servo selected, bytes next to the command range, byte extremes
      send_item(MODE_SERIAL, CHAR_UP, 1'b0);
      send_item(MODE_SERIAL, CHAR_DOWN, 1'b0);
      send_item(MODE_SERIAL, CHAR_SEL1 - 8'd1, 1'b0);
      send_item(MODE_SERIAL, CHAR_SER + 8'd1, 1'b0);
      send_item(MODE_SERIAL, 8'h00, 1'b0);
      send_item(MODE_SERIAL, 8'hFF, 1'b0);
      send_item(MODE_SERIAL, CHAR_SEL1, 1'b0);
      send_item(MODE_SERIAL, CHAR_UP, 1'b0);
      send_item(MODE_SERIAL, CHAR_DOWN, 1'b0);
      // samples at the extremes, then ADC control and copy back to serial
      send_item(MODE_ADC, 8'h00, 1'b0);
      send_item(MODE_ADC, 8'hFF, 1'b0);
      send_item(MODE_ADC, 8'd250, 1'b0);
      send_item(MODE_SERIAL, CHAR_ADC, 1'b0);
      send_item(MODE_SERIAL, CHAR_SER, 1'b0);
      // positions now 0, 255, 250: blocked steps at both ends, exact step to 255
      send_item(MODE_SERIAL, CHAR_SEL1, 1'b0);
      send_item(MODE_SERIAL, CHAR_DOWN, 1'b0);
      send_item(MODE_SERIAL, CHAR_SEL1 + 8'd1, 1'b0);
      send_item(MODE_SERIAL, CHAR_UP, 1'b0);
      send_item(MODE_SERIAL, CHAR_SEL3, 1'b0);
      send_item(MODE_SERIAL, CHAR_UP, 1'b0);
      send_item(MODE_SERIAL, CHAR_UP, 1'b0);
      send_item(MODE_SERIAL, CHAR_SEL1 + 8'd1, 1'b0);
      send_item(MODE_SERIAL, CHAR_DOWN, 1'b0);
      send_random(ITEMS_PER_PHASE);

      // full span, smallest step
      wait_for_results();
      set_widths(8'd0, 8'd255, 7'd1);
      send_random(ITEMS_PER_PHASE);

      // max below min, largest step
      wait_for_results();
      set_widths(8'd255, 8'd0, 7'd127);
      send_random(ITEMS_PER_PHASE);

      // zero step and zero span
      wait_for_results();
      set_widths(8'd100, 8'd100, 7'd0);
      send_random(ITEMS_PER_PHASE);

      // random settings
      wait_for_results();
      set_widths(byte_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)),
                 7'($urandom_range(1, 127)));
      send_random(ITEMS_PER_PHASE);

      wait_for_results();
      set_widths(byte_type'($urandom_range(0, 127)), byte_type'($urandom_range(128, 255)),
                 7'($urandom_range(1, 127)));
      send_random(ITEMS_PER_PHASE);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
